// ===== src/sdhs_pkg.sv =====
// Package for the SCAN disk head scheduler.
// Holds field widths, register indexes, reset values, the control state type,
// the cell control struct and the top-cylinder helper. No dependencies.
package sdhs_pkg;

    localparam int CYL_W            = 16;
    localparam int DISK_W           = 17;
    localparam int MOVE_W           = 17;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 17;
    localparam int DEF_MAX_REQUESTS = 16;

    localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_HEAD_START     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISK_CYLINDERS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_RIGHT    = 2'd2;

    localparam logic [CYL_W-1:0]  RST_HEAD_START     = '0;
    localparam logic [DISK_W-1:0] RST_DISK_CYLINDERS = 17'h10000;
    localparam logic              RST_SWEEP_RIGHT    = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CLAMP,
        ST_SPLIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic ins;
        logic clamp;
        logic clr;
    } t_chain_ctl;

    function automatic logic [CYL_W-1:0] top_of(input logic [DISK_W-1:0] disk);
        logic [DISK_W-1:0] dm1;
        dm1 = disk - DISK_W'(1);
        if (disk == '0) begin
            top_of = '0;
        end else if (disk > DISK_W'(17'h10000)) begin
            top_of = {CYL_W{1'b1}};
        end else begin
            top_of = dm1[CYL_W-1:0];
        end
    endfunction

endpackage

// ===== src/sdhs_cell.sv =====
// One cell of the sorted request chain: holds one cylinder and its valid bit.
// Takes a shifted value from its left neighbor or the new request on insert.
// Depends on sdhs_pkg.
module sdhs_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sdhs_pkg::t_chain_ctl     i_ctl,
    input  logic [sdhs_pkg::CYL_W-1:0] i_x,
    input  logic [sdhs_pkg::CYL_W-1:0] i_top,
    input  logic [sdhs_pkg::CYL_W-1:0] i_head,
    input  logic [sdhs_pkg::CYL_W-1:0] i_prev_val,
    input  logic                     i_prev_valid,
    input  logic                     i_prev_gt,
    output logic [sdhs_pkg::CYL_W-1:0] o_val,
    output logic                     o_valid,
    output logic                     o_gt,
    output logic                     o_below
);

    logic [sdhs_pkg::CYL_W-1:0] r_val, n_val;
    logic                       r_valid, n_valid;
    logic                       r_below, n_below;
    logic [sdhs_pkg::CYL_W-1:0] clamped;

    assign o_gt    = r_valid && (r_val > i_x);
    assign clamped = (r_val > i_top) ? i_top : r_val;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        n_below = r_below;
        priority if (i_ctl.clr) begin
            n_valid = 1'b0;
            n_below = 1'b0;
        end else if (i_ctl.ins) begin
            if (i_prev_gt) begin
                n_val   = i_prev_val;
                n_valid = 1'b1;
            end else if (i_prev_valid && (!r_valid || o_gt)) begin
                n_val   = i_x;
                n_valid = 1'b1;
            end
        end else if (i_ctl.clamp) begin
            n_val   = clamped;
            n_below = r_valid && (clamped < i_head);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_below <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_below <= n_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;
    assign o_below = r_below;

endmodule

// ===== src/sdhs_chain.sv =====
// Row of sdhs_cell instances forming the ascending insertion chain.
// Each cell sees its left neighbor's value, valid bit and compare result.
// Depends on sdhs_pkg and sdhs_cell.
module sdhs_chain #(
    parameter int MAX_REQUESTS = sdhs_pkg::DEF_MAX_REQUESTS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  sdhs_pkg::t_chain_ctl                     i_ctl,
    input  logic [sdhs_pkg::CYL_W-1:0]               i_x,
    input  logic [sdhs_pkg::CYL_W-1:0]               i_top,
    input  logic [sdhs_pkg::CYL_W-1:0]               i_head,
    output logic [MAX_REQUESTS-1:0][sdhs_pkg::CYL_W-1:0] o_vals,
    output logic [MAX_REQUESTS-1:0]                  o_below
);

    logic [MAX_REQUESTS-1:0] valid;
    logic [MAX_REQUESTS-1:0] gt;

    for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
        logic [sdhs_pkg::CYL_W-1:0] prev_val;
        logic                       prev_valid;
        logic                       prev_gt;

        if (g == 0) begin : g_first
            assign prev_val   = '0;
            assign prev_valid = 1'b1;
            assign prev_gt    = 1'b0;
        end else begin : g_rest
            assign prev_val   = o_vals[g-1];
            assign prev_valid = valid[g-1];
            assign prev_gt    = gt[g-1];
        end

        sdhs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_x          (i_x),
            .i_top        (i_top),
            .i_head       (i_head),
            .i_prev_val   (prev_val),
            .i_prev_valid (prev_valid),
            .i_prev_gt    (prev_gt),
            .o_val        (o_vals[g]),
            .o_valid      (valid[g]),
            .o_gt         (gt[g]),
            .o_below      (o_below[g])
        );
    end

endmodule

// ===== src/scan_disk_head_scheduler_top.sv =====
// Top level of the SCAN disk head scheduler: configuration registers,
// control sequencer, visit generation and output register.
// Depends on sdhs_pkg and sdhs_chain.

// Requests load one beat per cycle into a sorted chain of cells; a request
// that arrives with the chain full is dropped. The beat with batch_end set
// starts the sweep: input ready drops, ST_CLAMP and ST_SPLIT clamp the chain
// to the top cylinder and locate the head, then one visit per cycle leaves through
// the output register (n + 1 visits for n requests), paced only by output
// ready. Input ready returns in the cycle after the final visit is formed.
// Configuration writes are always taken and sampled at the batch_end beat.
module scan_disk_head_scheduler_top #(
    parameter int MAX_REQUESTS = sdhs_pkg::DEF_MAX_REQUESTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sdhs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sdhs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sdhs_pkg::CYL_W-1:0]          i_cylinder,
    input  logic                                i_batch_end,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sdhs_pkg::CYL_W-1:0]          o_visit_cylinder,
    output logic [sdhs_pkg::MOVE_W-1:0]         o_total_movement,
    output logic                                o_final_visit
);

    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    sdhs_pkg::t_state r_state, n_state;
    sdhs_pkg::t_chain_ctl ctl;

    logic [sdhs_pkg::CYL_W-1:0]  r_head_start;
    logic [sdhs_pkg::DISK_W-1:0] r_disk;
    logic                        r_sweep_right;

    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_split, n_split;
    logic [CW-1:0]               r_e;
    logic [sdhs_pkg::MOVE_W-1:0] r_sum;
    logic [sdhs_pkg::CYL_W-1:0]  r_pos;
    logic [sdhs_pkg::CYL_W-1:0]  r_top;
    logic                        r_dir;

    logic                        r_out_valid;
    logic [sdhs_pkg::CYL_W-1:0]  r_out_cyl;
    logic [sdhs_pkg::MOVE_W-1:0] r_out_sum;
    logic                        r_out_final;

    logic [MAX_REQUESTS-1:0][sdhs_pkg::CYL_W-1:0] vals;
    logic [MAX_REQUESTS-1:0]     below;

    logic                        in_beat;
    logic                        adv;
    logic                        e_last;
    logic [CW-1:0]               rem;
    logic [CW-1:0]               idx;
    logic                        is_end;
    logic [sdhs_pkg::CYL_W-1:0]  visit;
    logic [sdhs_pkg::CYL_W-1:0]  move_step;
    logic [sdhs_pkg::MOVE_W:0]   sum_wide;
    logic [sdhs_pkg::MOVE_W-1:0] sum_next;
    logic [sdhs_pkg::CYL_W-1:0]  head_clamped;
    logic [sdhs_pkg::CYL_W-1:0]  top_now;

    assign o_cfg_ready = 1'b1;
    assign in_beat     = i_in_valid && o_in_ready;
    assign top_now     = sdhs_pkg::top_of(r_disk);
    assign head_clamped = (r_head_start > top_now) ? top_now : r_head_start;

    sdhs_chain #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_x     (i_cylinder),
        .i_top   (r_top),
        .i_head  (r_pos),
        .o_vals  (vals),
        .o_below (below)
    );

    // Visit selection for the current step of the sweep.
    always_comb begin
        rem    = r_count - r_split;
        idx    = '0;
        is_end = 1'b0;
        if (r_dir) begin
            if (r_e < rem) begin
                idx = r_split + r_e;
            end else if (r_e == rem) begin
                is_end = 1'b1;
            end else begin
                idx = r_count - r_e;
            end
        end else begin
            if (r_e < r_split) begin
                idx = r_split - CW'(1) - r_e;
            end else if (r_e == r_split) begin
                is_end = 1'b1;
            end else begin
                idx = r_e - CW'(1);
            end
        end
        if (is_end) begin
            visit = r_dir ? r_top : '0;
        end else begin
            visit = vals[idx[IW-1:0]];
        end
        move_step = (visit >= r_pos) ? (visit - r_pos) : (r_pos - visit);
        sum_wide  = {1'b0, r_sum} + (sdhs_pkg::MOVE_W + 1)'(move_step);
        sum_next  = sum_wide[sdhs_pkg::MOVE_W] ? sdhs_pkg::MOVE_MAX
                                               : sum_wide[sdhs_pkg::MOVE_W-1:0];
        e_last    = (r_e == r_count);
    end

    always_comb begin
        n_split = '0;
        for (int k = 0; k < MAX_REQUESTS; k++) begin
            n_split = n_split + CW'(below[k]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdhs_pkg::ST_LOAD: begin
                if (in_beat && i_batch_end) begin
                    n_state = sdhs_pkg::ST_CLAMP;
                end
            end
            sdhs_pkg::ST_CLAMP: n_state = sdhs_pkg::ST_SPLIT;
            sdhs_pkg::ST_SPLIT: n_state = sdhs_pkg::ST_EMIT;
            sdhs_pkg::ST_EMIT: begin
                if (adv && e_last) begin
                    n_state = sdhs_pkg::ST_LOAD;
                end
            end
            default: n_state = sdhs_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        adv        = 1'b0;
        ctl        = '0;
        unique case (r_state)
            sdhs_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                ctl.ins    = in_beat && (r_count < CW'(MAX_REQUESTS));
            end
            sdhs_pkg::ST_CLAMP: ctl.clamp = 1'b1;
            sdhs_pkg::ST_SPLIT: ;
            sdhs_pkg::ST_EMIT: begin
                adv     = !r_out_valid || i_out_ready;
                ctl.clr = adv && e_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sdhs_pkg::ST_LOAD;
            r_head_start  <= sdhs_pkg::RST_HEAD_START;
            r_disk        <= sdhs_pkg::RST_DISK_CYLINDERS;
            r_sweep_right <= sdhs_pkg::RST_SWEEP_RIGHT;
            r_count       <= '0;
            r_e           <= '0;
            r_sum         <= '0;
            r_pos         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    sdhs_pkg::REG_HEAD_START:
                        r_head_start <= i_cfg_data[sdhs_pkg::CYL_W-1:0];
                    sdhs_pkg::REG_DISK_CYLINDERS:
                        r_disk <= i_cfg_data;
                    sdhs_pkg::REG_SWEEP_RIGHT:
                        r_sweep_right <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (ctl.ins) begin
                r_count <= r_count + CW'(1);
            end
            if (in_beat && i_batch_end) begin
                r_pos <= head_clamped;
                r_e   <= '0;
                r_sum <= '0;
            end
            if (adv) begin
                r_e   <= r_e + CW'(1);
                r_sum <= sum_next;
                r_pos <= visit;
                if (e_last) begin
                    r_count <= '0;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && i_batch_end) begin
            r_top <= top_now;
            r_dir <= r_sweep_right;
        end
        if (r_state == sdhs_pkg::ST_SPLIT) begin
            r_split <= n_split;
        end
        if (adv) begin
            r_out_cyl   <= visit;
            r_out_sum   <= sum_next;
            r_out_final <= e_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_visit_cylinder = r_out_cyl;
    assign o_total_movement = r_out_sum;
    assign o_final_visit    = r_out_final;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REQUESTS))
        else $error("request count exceeds chain depth");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sdhs_pkg::ST_EMIT |-> r_e <= r_count)
        else $error("sweep step beyond request count");

    a_clear_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && e_last |=> r_count == '0 && r_state == sdhs_pkg::ST_LOAD)
        else $error("chain not emptied after final visit");

    a_final_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid && !o_final_visit |-> 1'b0)
        else $error("input taken while a sweep is still delivering visits");
`endif

endmodule

// ===== tb/scan_disk_head_scheduler_top_test.sv =====
// Self-checking testbench for scan_disk_head_scheduler_top: request batches in, SCAN visits out.
// A scoreboard class predicts every visit, and plain tasks drive the handshakes.
// Depends on sdhs_pkg and the scheduler RTL.
module scan_disk_head_scheduler_top_test;
    import sdhs_pkg::*;

    localparam int QUEUE_DEPTH = DEF_MAX_REQUESTS;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_REQUESTS = 135;
    localparam int CALM_REQUESTS = 30;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [CYL_W-1:0] CYL_MAX = {CYL_W{1'b1}};

    typedef struct packed {
        logic [CYL_W-1:0]  cyl;
        logic [MOVE_W-1:0] move;
        logic              last;
    } t_visit;

    class sweep_scoreboard;
        bit [CYL_W-1:0]  head_start;
        bit [DISK_W-1:0] disk_cylinders;
        bit              sweep_right;
        bit [CYL_W-1:0]  requests [QUEUE_DEPTH];
        int              held;
        t_visit          visits [$];
        int              errors;

        function new();
            head_start     = RST_HEAD_START;
            disk_cylinders = RST_DISK_CYLINDERS;
            sweep_right    = RST_SWEEP_RIGHT;
            held           = 0;
            errors         = 0;
        endfunction

        function bit [CYL_W-1:0] top_cylinder();
            if (disk_cylinders == '0) return '0;
            if (disk_cylinders > DISK_W'(65536)) return CYL_MAX;
            return CYL_W'(disk_cylinders - 1);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_HEAD_START:     head_start = data[CYL_W-1:0];
                REG_DISK_CYLINDERS: disk_cylinders = data;
                REG_SWEEP_RIGHT:    sweep_right = data[0];
                default: ;
            endcase
        endfunction

        // Requests are kept sorted; the batch_end beat turns them into the visit order.
        function void note_request(bit [CYL_W-1:0] cyl, bit last);
            bit [CYL_W-1:0] top;
            bit [CYL_W-1:0] head;
            bit [CYL_W-1:0] order [$];
            int             pos;
            int             split;
            int unsigned    sum;
            t_visit         v;
            if (held < QUEUE_DEPTH) begin
                pos = held;
                while (pos > 0 && requests[pos-1] > cyl) begin
                    requests[pos] = requests[pos-1];
                    pos--;
                end
                requests[pos] = cyl;
                held++;
            end
            if (!last) return;
            top = top_cylinder();
            for (int k = 0; k < held; k++) begin
                if (requests[k] > top) requests[k] = top;
            end
            head = (head_start > top) ? top : head_start;
            split = held;
            for (int k = held - 1; k >= 0; k--) begin
                if (requests[k] >= head) split = k;
            end
            if (sweep_right) begin
                for (int k = split; k < held; k++) order.push_back(requests[k]);
                order.push_back(top);
                for (int k = split - 1; k >= 0; k--) order.push_back(requests[k]);
            end else begin
                for (int k = split - 1; k >= 0; k--) order.push_back(requests[k]);
                order.push_back('0);
                for (int k = split; k < held; k++) order.push_back(requests[k]);
            end
            sum = 0;
            foreach (order[k]) begin
                sum += (order[k] >= head) ? order[k] - head : head - order[k];
                if (sum > MOVE_MAX) sum = MOVE_MAX;
                head = order[k];
                v.cyl  = order[k];
                v.move = sum[MOVE_W-1:0];
                v.last = (k == order.size() - 1);
                visits.push_back(v);
            end
            held = 0;
        endfunction

        function void check_visit(logic [CYL_W-1:0] cyl, logic [MOVE_W-1:0] move, logic last);
            t_visit want;
            if (visits.size() == 0) begin
                $error("visit_cylinder %0d arrived with no visit expected", cyl);
                errors++;
                return;
            end
            want = visits.pop_front();
            if (cyl !== want.cyl) begin
                $error("visit_cylinder: expected %0d, actual %0d", want.cyl, cyl);
                errors++;
            end
            if (move !== want.move) begin
                $error("total_movement: expected %0d, actual %0d", want.move, move);
                errors++;
            end
            if (last !== want.last) begin
                $error("final_visit: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return visits.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [CYL_W-1:0]      i_cylinder;
    logic                  i_batch_end;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [CYL_W-1:0]      o_visit_cylinder;
    logic [MOVE_W-1:0]     o_total_movement;
    logic                  o_final_visit;

    bit calm;
    bit in_gappy;
    bit out_gappy;

    sweep_scoreboard board = new();

    scan_disk_head_scheduler_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cylinder       (i_cylinder),
        .i_batch_end      (i_batch_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_visit_cylinder (o_visit_cylinder),
        .o_total_movement (o_total_movement),
        .o_final_visit    (o_final_visit)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] head, logic [CFG_DATA_W-1:0] disk,
                             logic right);
        set_register(REG_HEAD_START, head);
        set_register(REG_DISK_CYLINDERS, disk);
        set_register(REG_SWEEP_RIGHT, CFG_DATA_W'(right));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_request(logic [CYL_W-1:0] cyl, logic last);
        @(negedge i_clk);
        if (!calm && $urandom_range(9, 0) == 0) in_gappy = ~in_gappy;
        if (!calm && in_gappy && $urandom_range(2, 0) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cylinder  <= cyl;
        i_batch_end <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(cyl, last);
    endtask

    task automatic send_batch(logic [CYL_W-1:0] cyls [$]);
        foreach (cyls[k]) send_request(cyls[k], k == cyls.size() - 1);
    endtask

    // The block is idle once every visit is back and its ready has had time to return.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [CYL_W-1:0] pick_cylinder(logic [CYL_W-1:0] prev);
        logic [CYL_W-1:0] top;
        top = board.top_cylinder();
        case ($urandom_range(9, 0))
            0: return '0;
            1: return top;
            2: return board.head_start;
            3: return prev;
            4: return CYL_W'($urandom);
            5: return (top == CYL_MAX) ? CYL_MAX : CYL_W'($urandom_range(CYL_MAX, top + 1));
            default: return CYL_W'($urandom_range(top, 0));
        endcase
    endfunction

    task automatic random_config();
        logic [CFG_DATA_W-1:0] head;
        logic [CFG_DATA_W-1:0] disk;
        int unsigned           top;
        case ($urandom_range(5, 0))
            0: disk = 17'd1;
            1: disk = CFG_DATA_W'($urandom_range(300, 2));
            2: disk = 17'h10000;
            3: disk = '0;
            4: disk = CFG_DATA_W'($urandom_range(131071, 65537));
            default: disk = CFG_DATA_W'($urandom_range(65536, 1));
        endcase
        top = (disk == 0) ? 0 : (disk > 65536) ? 65535 : disk - 1;
        case ($urandom_range(4, 0))
            0: head = '0;
            1: head = 17'h0FFFF;
            2: head = CFG_DATA_W'($urandom_range(131071, 0));
            default: head = CFG_DATA_W'($urandom_range(top, 0));
        endcase
        configure(head, disk, 1'($urandom_range(1, 0)));
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(39, 0) == 0) out_gappy = ~out_gappy;
            if (!calm && out_gappy && $urandom_range(3, 0) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(18, 1)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            board.check_visit(o_visit_cylinder, o_total_movement, o_final_visit);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready) ||
                (o_out_valid && i_out_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [CYL_W-1:0] batch [$];
        logic [CYL_W-1:0] prev;
        int               sent;
        int               len;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_HEAD_START;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_cylinder  = '0;
        i_batch_end = 1'b0;
        calm        = 1'b0;
        in_gappy    = 1'b0;
        out_gappy   = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: full disk, head at zero, sweeping right.
        batch = {16'hFFFF, 16'h0000};
        send_batch(batch);
        settle();

        // Clamping, duplicates, a request at the head and one at the end cylinder.
        set_register(REG_SPARE, 17'h1ABCD);
        configure(17'd100, 17'd200, 1'b0);
        batch = {16'd150, 16'd100, 16'd300, 16'd50, 16'd50, 16'd0};
        send_batch(batch);
        settle();

        // An empty disk size with the head above the top, then one above the largest disk.
        configure(17'h0FFFF, 17'd0, 1'b1);
        batch = {16'd7};
        send_batch(batch);
        settle();
        configure(17'h1FFFF, 17'h1FFFF, 1'b0);
        batch = {16'hFFFF};
        send_batch(batch);
        settle();

        // More requests than the store holds.
        configure(17'd40000, 17'h10000, 1'b1);
        batch.delete();
        repeat (QUEUE_DEPTH + 1) batch.push_back(CYL_W'($urandom));
        send_batch(batch);
        settle();

        sent = 0;
        prev = '0;
        while (sent < RANDOM_REQUESTS) begin
            if (sent >= RANDOM_REQUESTS - CALM_REQUESTS) calm = 1'b1;
            random_config();
            repeat ($urandom_range(3, 1)) begin
                batch.delete();
                len = ($urandom_range(4, 0) == 0) ? $urandom_range(20, 16) : $urandom_range(12, 1);
                repeat (len) begin
                    prev = pick_cylinder(prev);
                    batch.push_back(prev);
                end
                send_batch(batch);
                sent += len;
            end
            settle();
        end

        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
